### src/rhsv_pkg.sv
package rhsv_pkg;

    // Quotient bits produced by the divider chain, one per cell
    localparam int QUO_W = 7;
    // Partial remainder and shifted divisor width
    localparam int REM_W = 16;

    // Sector offsets in degrees
    localparam logic [8:0] HUE_OFS_RED     = 9'd0;
    localparam logic [8:0] HUE_OFS_RED_NEG = 9'd360;
    localparam logic [8:0] HUE_OFS_GREEN   = 9'd120;
    localparam logic [8:0] HUE_OFS_BLUE    = 9'd240;

    // Reciprocal of 510 scaled by 2^24, exact for numerators below 66052
    localparam logic [15:0] RECIP_510   = 16'd32897;
    localparam int          RECIP_SHIFT = 24;

    // One division lane travelling down the chain
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } lane_t;

    // Sideband carried alongside the division lanes
    typedef struct packed {
        logic [8:0] offset;
        logic       neg;
        logic       hue_zero;
        logic       sat_zero;
        logic [6:0] bri;
    } side_t;

endpackage

### src/rhsv_prep.sv
module rhsv_prep
    import rhsv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    output lane_t      out_hue,
    output lane_t      out_sat,
    output side_t      out_side
);

    logic        red_max, green_max;
    logic [7:0]  hi, lo, dlt, mag;
    logic        neg;
    logic [8:0]  ofs;
    logic [15:0] num_h, num_s, num_b;
    logic [31:0] prod_b;
    logic        valid_reg;
    lane_t       hue_reg, sat_reg;
    side_t       side_reg;

    // Max/min selection, red wins ties then green
    always_comb begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        if (red_max) begin
            hi  = red;
            neg = green < blue;
            mag = neg ? (blue - green) : (green - blue);
            ofs = neg ? HUE_OFS_RED_NEG : HUE_OFS_RED;
        end else if (green_max) begin
            hi  = green;
            neg = blue < red;
            mag = neg ? (red - blue) : (blue - red);
            ofs = HUE_OFS_GREEN;
        end else begin
            hi  = blue;
            neg = red < green;
            mag = neg ? (green - red) : (red - green);
            ofs = HUE_OFS_BLUE;
        end
        lo = red;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;
        dlt    = hi - lo;
        num_h  = 16'(mag) * 16'd60;
        num_s  = 16'(hi) * 16'd201 - 16'(lo) * 16'd200;
        num_b  = 16'(hi) * 16'd200 + 16'd255;
        prod_b = 32'(num_b) * 32'(RECIP_510);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg.rem <= num_h;
            hue_reg.dvs <= {2'b00, dlt, 6'b000000};
            hue_reg.quo <= '0;
            sat_reg.rem <= num_s;
            sat_reg.dvs <= {1'b0, hi, 7'b0000000};
            sat_reg.quo <= '0;
            side_reg.offset   <= ofs;
            side_reg.neg      <= neg;
            side_reg.hue_zero <= (dlt == 8'd0);
            side_reg.sat_zero <= (hi == 8'd0);
            side_reg.bri      <= prod_b[RECIP_SHIFT+6:RECIP_SHIFT];
        end
    end

    assign out_valid = valid_reg;
    assign out_hue   = hue_reg;
    assign out_sat   = sat_reg;
    assign out_side  = side_reg;

endmodule

### src/rhsv_cell.sv
module rhsv_cell
    import rhsv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  lane_t in_hue,
    input  lane_t in_sat,
    input  side_t in_side,
    output logic  out_valid,
    output lane_t out_hue,
    output lane_t out_sat,
    output side_t out_side
);

    logic  valid_reg;
    lane_t hue_reg, sat_reg, hue_next, sat_next;
    side_t side_reg;

    // One restoring step on a lane: compare, subtract, shift divisor down
    function automatic lane_t div_step(input lane_t l);
        lane_t o;
        logic  ge;
        ge    = l.rem >= l.dvs;
        o.rem = ge ? (l.rem - l.dvs) : l.rem;
        o.dvs = l.dvs >> 1;
        o.quo = {l.quo[QUO_W-2:0], ge};
        return o;
    endfunction

    always_comb begin
        hue_next = div_step(in_hue);
        sat_next = div_step(in_sat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg  <= hue_next;
            sat_reg  <= sat_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_hue   = hue_reg;
    assign out_sat   = sat_reg;
    assign out_side  = side_reg;

endmodule

### src/rgb_to_hsv_pixel.sv
// Pipeline: input transfer to result valid passes through 1 prepare stage,
// 7 divider cells and 1 output register; the cell count is set by the 7
// quotient bits of the hue and saturation divisions.
// Throughput: one pixel per cycle; the whole chain stalls only while the
// output register holds a result that is not taken.
// Reset: synchronous active-low aresetn clears every stage valid bit.
module rgb_to_hsv_pixel
    import rhsv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [8:0] m_hue,
    output logic [6:0] m_saturation,
    output logic [6:0] m_brightness
);

    logic  en;
    logic  vld  [QUO_W+1];
    lane_t hue_l[QUO_W+1];
    lane_t sat_l[QUO_W+1];
    side_t side_l[QUO_W+1];
    logic  [8:0] hue_next;
    logic  [6:0] sat_next;
    logic        valid_reg;
    logic  [8:0] hue_reg;
    logic  [6:0] sat_reg, bri_reg;

    // Chain advances whenever the output register is free or being drained
    assign en      = !valid_reg || m_ready;
    assign s_ready = en;

    rhsv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .out_valid (vld[0]),
        .out_hue   (hue_l[0]),
        .out_sat   (sat_l[0]),
        .out_side  (side_l[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        rhsv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld[i]),
            .in_hue    (hue_l[i]),
            .in_sat    (sat_l[i]),
            .in_side   (side_l[i]),
            .out_valid (vld[i+1]),
            .out_hue   (hue_l[i+1]),
            .out_sat   (sat_l[i+1]),
            .out_side  (side_l[i+1])
        );
    end

    // Apply sector offset and sign; hue forced to zero for grey, saturation for black
    always_comb begin
        if (side_l[QUO_W].hue_zero) begin
            hue_next = 9'd0;
        end else if (side_l[QUO_W].neg) begin
            hue_next = side_l[QUO_W].offset - 9'(hue_l[QUO_W].quo);
        end else begin
            hue_next = side_l[QUO_W].offset + 9'(hue_l[QUO_W].quo);
        end
        sat_next = side_l[QUO_W].sat_zero ? 7'd0 : sat_l[QUO_W].quo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= vld[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= side_l[QUO_W].bri;
        end
    end

    assign m_valid      = valid_reg;
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bri_reg;

    // Checks
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue))
        else $error("result dropped or changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output drain");
    a_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hue <= 9'd360)
        else $error("hue out of range");
    a_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_saturation <= 7'd100) && (m_brightness <= 7'd100))
        else $error("percentage out of range");

endmodule
